@@ hdl/qcor_pkg.sv @@
// Package: shared types and constants for the quarter-circle outline rasterizer.
`default_nettype none
package qcor_pkg;

	localparam int COORD_W   = 16;
	localparam int RAD_W     = 7;
	localparam int MASK_W    = 4;
	localparam int COLOR_W   = 16;
	localparam int ERR_W     = 10;  // error and step terms, radius up to 127
	localparam int MAX_RESULTS = 48;
	localparam int CNT_W     = 6;

	// corner mask bits
	localparam logic [MASK_W-1:0] CORNER_UL = 4'h1;
	localparam logic [MASK_W-1:0] CORNER_UR = 4'h2;
	localparam logic [MASK_W-1:0] CORNER_LR = 4'h4;
	localparam logic [MASK_W-1:0] CORNER_LL = 4'h8;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} qcor_state_t;

	typedef struct packed {
		logic load;
		logic step;
	} qcor_cmd_t;

	typedef struct packed {
		logic zero_radius;
		logic last;
	} qcor_status_t;

endpackage
`default_nettype wire

@@ hdl/qcor_ctrl.sv @@
// Controller: sequences one command from load through its iterations.
`default_nettype none
module qcor_ctrl (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	input  qcor_pkg::qcor_status_t status,
	output qcor_pkg::qcor_cmd_t   cmd,
	output logic                  busy
);
	import qcor_pkg::*;

	qcor_state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		busy     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				// zero radius: transaction taken, nothing to draw
				if (start && !status.zero_radius) begin
					cmd.load = 1'b1;
					state_d  = ST_RUN;
				end
			end
			ST_RUN: begin
				busy     = 1'b1;
				cmd.step = 1'b1;
				if (status.last) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/qcor_dp.sv @@
// Datapath: midpoint recurrence registers and registered result outputs.
`default_nettype none
module qcor_dp #(
	parameter int MAX_RADIUS = 64
) (
	input  wire                                clk,
	input  wire                                arst_n,
	input  qcor_pkg::qcor_cmd_t                cmd,
	output qcor_pkg::qcor_status_t             status,
	input  wire signed [qcor_pkg::COORD_W-1:0] center_x,
	input  wire signed [qcor_pkg::COORD_W-1:0] center_y,
	input  wire        [qcor_pkg::RAD_W-1:0]   radius,
	input  wire        [qcor_pkg::MASK_W-1:0]  corner_mask,
	input  wire        [qcor_pkg::COLOR_W-1:0] color,
	output logic                               result_strobe,
	output logic signed [qcor_pkg::COORD_W-1:0] cx_plus_x,
	output logic signed [qcor_pkg::COORD_W-1:0] cx_minus_x,
	output logic signed [qcor_pkg::COORD_W-1:0] cx_plus_y,
	output logic signed [qcor_pkg::COORD_W-1:0] cx_minus_y,
	output logic signed [qcor_pkg::COORD_W-1:0] cy_plus_x,
	output logic signed [qcor_pkg::COORD_W-1:0] cy_minus_x,
	output logic signed [qcor_pkg::COORD_W-1:0] cy_plus_y,
	output logic signed [qcor_pkg::COORD_W-1:0] cy_minus_y,
	output logic       [qcor_pkg::MASK_W-1:0]  corners_out,
	output logic       [qcor_pkg::COLOR_W-1:0] color_out,
	output logic                               last_step
);
	import qcor_pkg::*;

	localparam logic [RAD_W-1:0] RAD_LIMIT = RAD_W'(MAX_RADIUS);

	logic [RAD_W-1:0]   x_q, y_q, x_n, y_n, r_sat;
	logic [ERR_W-1:0]   f_q, fx_q, fy_q, f_n, fx_n, fy_n;
	logic [CNT_W-1:0]   n_q, n_n;
	logic [COORD_W-1:0] cx_q, cy_q, x_ext, y_ext;
	logic [MASK_W-1:0]  mask_q;
	logic [COLOR_W-1:0] color_q;
	logic               f_ge;
	logic               strobe_q;

	assign r_sat = (radius > RAD_LIMIT) ? RAD_LIMIT : radius;

	// one recurrence iteration
	always_comb begin
		f_ge = ~f_q[ERR_W-1];
		y_n  = f_ge ? y_q - RAD_W'(1) : y_q;
		fy_n = f_ge ? fy_q + ERR_W'(2) : fy_q;
		x_n  = x_q + RAD_W'(1);
		fx_n = fx_q + ERR_W'(2);
		f_n  = f_q + (f_ge ? fy_n : '0) + fx_n;
		n_n  = n_q + CNT_W'(1);
	end

	assign x_ext = COORD_W'(x_n);
	assign y_ext = COORD_W'(y_n);

	assign status.zero_radius = (radius == '0);
	assign status.last        = (x_n >= y_n) || (n_n == CNT_W'(MAX_RESULTS));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			x_q     <= '0;
			y_q     <= r_sat;
			f_q     <= ERR_W'(1) - ERR_W'(r_sat);
			fx_q    <= ERR_W'(1);
			fy_q    <= '0 - (ERR_W'(r_sat) << 1);
			n_q     <= '0;
			cx_q    <= center_x;
			cy_q    <= center_y;
			mask_q  <= corner_mask;
			color_q <= color;
		end else if (cmd.step) begin
			x_q  <= x_n;
			y_q  <= y_n;
			f_q  <= f_n;
			fx_q <= fx_n;
			fy_q <= fy_n;
			n_q  <= n_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) begin
			cx_plus_x   <= cx_q + x_ext;
			cx_minus_x  <= cx_q - x_ext;
			cx_plus_y   <= cx_q + y_ext;
			cx_minus_y  <= cx_q - y_ext;
			cy_plus_x   <= cy_q + x_ext;
			cy_minus_x  <= cy_q - x_ext;
			cy_plus_y   <= cy_q + y_ext;
			cy_minus_y  <= cy_q - y_ext;
			corners_out <= mask_q;
			color_out   <= color_q;
			last_step   <= status.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.step;
		end
	end

	assign result_strobe = strobe_q;

endmodule
`default_nettype wire

@@ hdl/quarter_circle_outline_raster.sv @@
// Top level: quarter-circle outline rasterizer, controller plus datapath.
//
//  channel   | handshake               | payload
//  ----------+-------------------------+------------------------------------------
//  command   | start, busy (in)        | center_x, center_y, radius, corner_mask,
//            | taken: start & !busy    | color
//  result    | result_strobe (out)     | cx/cy plus/minus x/y, corners_out,
//            | one cycle, no backpress | color_out, last_step
//
// Steps: a command with radius r > 0 is loaded, then runs N iterations,
//   N = number of midpoint steps while x < y (about r/sqrt(2), capped
//   at 48); radius 64 gives 46 steps. The shared recurrence unit in the
//   datapath does one step per cycle.
// Radius 0 is taken as a transaction with no results; busy stays low.
// Radius above MAX_RADIUS is clipped to MAX_RADIUS.
// Reset clears the controller and the result strobe; payload is not reset.
// The receiver cannot stall: each result shows for exactly one cycle, and a
//   new command is taken in the same cycle the last result of the prior one shows.
`default_nettype none
module quarter_circle_outline_raster #(
	parameter int MAX_RADIUS = 64
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 start,
	output logic                                busy,
	input  wire signed [qcor_pkg::COORD_W-1:0]  center_x,
	input  wire signed [qcor_pkg::COORD_W-1:0]  center_y,
	input  wire        [qcor_pkg::RAD_W-1:0]    radius,
	input  wire        [qcor_pkg::MASK_W-1:0]   corner_mask,
	input  wire        [qcor_pkg::COLOR_W-1:0]  color,
	output logic                                result_strobe,
	output logic signed [qcor_pkg::COORD_W-1:0] cx_plus_x,
	output logic signed [qcor_pkg::COORD_W-1:0] cx_minus_x,
	output logic signed [qcor_pkg::COORD_W-1:0] cx_plus_y,
	output logic signed [qcor_pkg::COORD_W-1:0] cx_minus_y,
	output logic signed [qcor_pkg::COORD_W-1:0] cy_plus_x,
	output logic signed [qcor_pkg::COORD_W-1:0] cy_minus_x,
	output logic signed [qcor_pkg::COORD_W-1:0] cy_plus_y,
	output logic signed [qcor_pkg::COORD_W-1:0] cy_minus_y,
	output logic       [qcor_pkg::MASK_W-1:0]   corners_out,
	output logic       [qcor_pkg::COLOR_W-1:0]  color_out,
	output logic                                last_step
);
	import qcor_pkg::*;

	// command and status between controller and datapath
	qcor_cmd_t    cmd;
	qcor_status_t status;

	// controller: idle until a transaction with nonzero radius, then steps
	// once per cycle until the datapath flags the final iteration
	qcor_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.status (status),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath: captures the command, runs the error/step recurrence and
	// registers the eight mirrored coordinates per step
	qcor_dp #(
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.status        (status),
		.center_x      (center_x),
		.center_y      (center_y),
		.radius        (radius),
		.corner_mask   (corner_mask),
		.color         (color),
		.result_strobe (result_strobe),
		.cx_plus_x     (cx_plus_x),
		.cx_minus_x    (cx_minus_x),
		.cx_plus_y     (cx_plus_y),
		.cx_minus_y    (cx_minus_y),
		.cy_plus_x     (cy_plus_x),
		.cy_minus_x    (cy_minus_x),
		.cy_plus_y     (cy_plus_y),
		.cy_minus_y    (cy_minus_y),
		.corners_out   (corners_out),
		.color_out     (color_out),
		.last_step     (last_step)
	);

endmodule
`default_nettype wire

@@ hdl/qcor_chk.sv @@
// Checker: port-level properties of the rasterizer, bound to the top level.
`default_nettype none
module qcor_chk (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             start,
	input wire                             busy,
	input wire [qcor_pkg::RAD_W-1:0]       radius,
	input wire                             result_strobe,
	input wire                             last_step
);
	import qcor_pkg::*;

	// a transaction with nonzero radius makes the block busy next cycle
	a_busy_after_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && radius != '0) |=> busy)
		else $error("busy not raised after command");

	// zero radius gives no work
	a_zero_radius_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && radius == '0) |=> (!busy && !result_strobe))
		else $error("zero radius started work");

	// results of one command come in an unbroken run
	a_steps_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && !last_step) |=> result_strobe)
		else $error("gap inside a command's results");

	// after the final result a new command needs a load cycle first
	a_gap_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(result_strobe && last_step) |=> !result_strobe)
		else $error("result right after last step");

	// every result comes from a busy cycle
	a_strobe_from_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> $past(busy))
		else $error("result while idle");

endmodule

bind quarter_circle_outline_raster qcor_chk u_qcor_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.radius        (radius),
	.result_strobe (result_strobe),
	.last_step     (last_step)
);
`default_nettype wire

@@ tb/quarter_circle_outline_raster_tb.sv @@
// Self-checking testbench for quarter_circle_outline_raster: random circle commands against a midpoint circle predictor.
module quarter_circle_outline_raster_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import qcor_pkg::*;

	localparam int MAX_RAD      = 64;     // radius clip of the DUT instance
	localparam int N_RANDOM     = 380;    // random commands after the directed list
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 64;     // longer than one full radius-64 command

	// one command transaction plus the idle cycles the driver waits before it
	typedef struct packed {
		logic signed [COORD_W-1:0] cx;
		logic signed [COORD_W-1:0] cy;
		logic [RAD_W-1:0]          rad;
		logic [MASK_W-1:0]         mask;
		logic [COLOR_W-1:0]        color;
		logic [7:0]                gap;
	} circle_cmd_t;

	// one octant step: xy[0..7] = cx+x, cx-x, cx+y, cx-y, cy+x, cy-x, cy+y, cy-y
	typedef struct packed {
		logic [7:0][COORD_W-1:0] xy;
		logic [MASK_W-1:0]       corners;
		logic [COLOR_W-1:0]      color;
		logic                    last;
	} octant_point_t;

	logic clk;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [COORD_W-1:0] center_x;
	logic signed [COORD_W-1:0] center_y;
	logic [RAD_W-1:0]          radius;
	logic [MASK_W-1:0]         corner_mask;
	logic [COLOR_W-1:0]        color;
	logic                      result_strobe;
	logic signed [COORD_W-1:0] cx_plus_x;
	logic signed [COORD_W-1:0] cx_minus_x;
	logic signed [COORD_W-1:0] cx_plus_y;
	logic signed [COORD_W-1:0] cx_minus_y;
	logic signed [COORD_W-1:0] cy_plus_x;
	logic signed [COORD_W-1:0] cy_minus_x;
	logic signed [COORD_W-1:0] cy_plus_y;
	logic signed [COORD_W-1:0] cy_minus_y;
	logic [MASK_W-1:0]         corners_out;
	logic [COLOR_W-1:0]        color_out;
	logic                      last_step;

	circle_cmd_t   pending_cmds[$];    // commands not yet presented to the DUT
	octant_point_t expected_points[$]; // predicted octant points, oldest first

	// driver state
	circle_cmd_t next_cmd;
	bit          next_ok;
	int          gap_left;
	logic        took_cmd;             // command transaction taken at the last rising edge

	int cmds_taken;
	int flat_cmds;
	int clipped_cmds;
	int points_seen;
	int error_count;
	int cycle_count;
	bit burst;

	string coord_name[8] = '{"cx_plus_x", "cx_minus_x", "cx_plus_y", "cx_minus_y",
		"cy_plus_x", "cy_minus_x", "cy_plus_y", "cy_minus_y"};

	quarter_circle_outline_raster #(
		.MAX_RADIUS(MAX_RAD)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.center_x(center_x),
		.center_y(center_y),
		.radius(radius),
		.corner_mask(corner_mask),
		.color(color),
		.result_strobe(result_strobe),
		.cx_plus_x(cx_plus_x),
		.cx_minus_x(cx_minus_x),
		.cx_plus_y(cx_plus_y),
		.cx_minus_y(cx_minus_y),
		.cy_plus_x(cy_plus_x),
		.cy_minus_x(cy_minus_x),
		.cy_plus_y(cy_plus_y),
		.cy_minus_y(cy_minus_y),
		.corners_out(corners_out),
		.color_out(color_out),
		.last_step(last_step)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Midpoint circle recurrence. The error and step terms are updated before
	// each point is produced, so x = 0 never shows up. Radius above the clip
	// is saturated; radius 0 produces nothing. Coordinates wrap to 16 bits.
	task automatic trace_octant(input circle_cmd_t c);
		int r;
		int f;
		int fx;
		int fy;
		int x;
		int y;
		int n;
		octant_point_t p;
		r = (c.rad > MAX_RAD) ? MAX_RAD : int'(c.rad);
		f = 1 - r;
		fx = 1;
		fy = -2 * r;
		x = 0;
		y = r;
		n = 0;
		while (x < y && n < MAX_RESULTS) begin
			if (f >= 0) begin
				y--;
				fy += 2;
				f += fy;
			end
			x++;
			fx += 2;
			f += fx;
			p.xy[0] = c.cx + COORD_W'(x);
			p.xy[1] = c.cx - COORD_W'(x);
			p.xy[2] = c.cx + COORD_W'(y);
			p.xy[3] = c.cx - COORD_W'(y);
			p.xy[4] = c.cy + COORD_W'(x);
			p.xy[5] = c.cy - COORD_W'(x);
			p.xy[6] = c.cy + COORD_W'(y);
			p.xy[7] = c.cy - COORD_W'(y);
			p.corners = c.mask;
			p.color = c.color;
			p.last = 1'b0;
			expected_points.push_back(p);
			n++;
		end
		// only the final point of a command is flagged
		if (n > 0)
			expected_points[expected_points.size() - 1].last = 1'b1;
	endtask

	// Compare one strobed result against the oldest prediction, field by field.
	task automatic check_point();
		octant_point_t want;
		logic [7:0][COORD_W-1:0] got;
		got = {cy_minus_y, cy_plus_y, cy_minus_x, cy_plus_x,
			cx_minus_y, cx_plus_y, cx_minus_x, cx_plus_x};
		points_seen++;
		if (expected_points.size() == 0) begin
			$display("%0t: unexpected result, nothing predicted (cx_plus_x %h last_step %b)",
				$time, cx_plus_x, last_step);
			error_count++;
			return;
		end
		want = expected_points.pop_front();
		for (int i = 0; i < 8; i++) begin
			if (got[i] !== want.xy[i]) begin
				$display("%0t: %s expected %h got %h", $time, coord_name[i], want.xy[i], got[i]);
				error_count++;
			end
		end
		if (corners_out !== want.corners) begin
			$display("%0t: corners_out expected %h got %h", $time, want.corners, corners_out);
			error_count++;
		end
		if (color_out !== want.color) begin
			$display("%0t: color_out expected %h got %h", $time, want.color, color_out);
			error_count++;
		end
		if (last_step !== want.last) begin
			$display("%0t: last_step expected %b got %b", $time, want.last, last_step);
			error_count++;
		end
	endtask

	function automatic circle_cmd_t make_cmd(input int cx, input int cy, input int rad,
		input int mask, input int col, input int gap);
		circle_cmd_t c;
		c.cx = COORD_W'(cx);
		c.cy = COORD_W'(cy);
		c.rad = RAD_W'(rad);
		c.mask = MASK_W'(mask);
		c.color = COLOR_W'(col);
		c.gap = 8'(gap);
		return c;
	endfunction

	// Centers cluster near both wrap points a good share of the time.
	function automatic int pick_center();
		case ($urandom_range(0, 3))
			0: return 32767 - int'($urandom_range(0, 70));
			1: return -32768 + int'($urandom_range(0, 70));
			default: return int'($urandom_range(0, 65535)) - 32768;
		endcase
	endfunction

	// Mostly full-range radii; some zero, some above the clip.
	function automatic int pick_radius();
		case ($urandom_range(0, 19))
			0: return 0;
			1: return $urandom_range(MAX_RAD + 1, 127);
			2, 3, 4: return $urandom_range(1, 8);
			default: return $urandom_range(1, MAX_RAD);
		endcase
	endfunction

	// Driver: changes inputs on the falling edge. A command stays on the bus
	// until a rising edge sees start high and busy low; then the next command
	// follows after its drawn idle gap (zero gap keeps start high).
	always @(negedge clk) begin
		if (arst_n && !(start && !took_cmd)) begin
			if (!next_ok && pending_cmds.size() > 0) begin
				next_cmd = pending_cmds.pop_front();
				next_ok = 1'b1;
				gap_left = next_cmd.gap;
			end
			if (next_ok && gap_left == 0) begin
				center_x <= next_cmd.cx;
				center_y <= next_cmd.cy;
				radius <= next_cmd.rad;
				corner_mask <= next_cmd.mask;
				color <= next_cmd.color;
				start <= 1'b1;
				next_ok = 1'b0;
			end else begin
				start <= 1'b0;
				if (next_ok)
					gap_left--;
			end
		end
	end

	// Monitor: samples at the rising edge. Results are checked before a new
	// command's predictions are queued, since the DUT can take a command in
	// the same cycle the prior one's last point shows.
	always @(posedge clk) begin
		if (arst_n) begin
			if (result_strobe === 1'b1)
				check_point();
			if (start && !busy) begin
				cmds_taken++;
				if (radius == 0)
					flat_cmds++;
				if (radius > MAX_RAD)
					clipped_cmds++;
				trace_octant(make_cmd(center_x, center_y, radius, corner_mask, color, 0));
			end
			took_cmd <= start && !busy;
		end
	end

	// Watchdog.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("%0t: timeout after %0d cycles, %0d points still expected",
				$time, cycle_count, expected_points.size());
			$display("quarter_circle_outline_raster regression: fail");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		center_x = '0;
		center_y = '0;
		radius = '0;
		corner_mask = '0;
		color = '0;
		took_cmd = 1'b0;
		next_ok = 1'b0;
		gap_left = 0;
		cmds_taken = 0;
		flat_cmds = 0;
		clipped_cmds = 0;
		points_seen = 0;
		error_count = 0;
		cycle_count = 0;
		burst = 1'b0;

		// Directed: zero radius, smallest radii, each corner alone, mask empty
		// and full, color extremes, wrap at both ends, clipped radii, and
		// back-to-back commands including zero radius ones.
		pending_cmds.push_back(make_cmd(0, 0, 0, CORNER_UL, 'h0000, 0));
		pending_cmds.push_back(make_cmd(0, 0, 1, 'hF, 'hFFFF, 0));
		pending_cmds.push_back(make_cmd(100, -100, 2, CORNER_UR, 'h1234, 3));
		pending_cmds.push_back(make_cmd(-100, 100, 3, CORNER_LR, 'hA5A5, 0));
		pending_cmds.push_back(make_cmd(5, 5, 4, CORNER_LL, 'h5A5A, 1));
		pending_cmds.push_back(make_cmd(0, 0, MAX_RAD, 'hF, 'h0000, 0));
		pending_cmds.push_back(make_cmd(32767, 32767, MAX_RAD, 'hF, 'hFFFF, 2));
		pending_cmds.push_back(make_cmd(-32768, -32768, MAX_RAD, 'hF, 'h8001, 0));
		pending_cmds.push_back(make_cmd(32767, -32768, MAX_RAD, 'h0, 'h7FFE, 0));
		pending_cmds.push_back(make_cmd(-32768, 32767, MAX_RAD + 1, 'hF, 'hFFFF, 5));
		pending_cmds.push_back(make_cmd(-1, 1, 127, CORNER_UL | CORNER_LR, 'h0001, 0));
		pending_cmds.push_back(make_cmd(1234, -4321, 100, CORNER_UR | CORNER_LL, 'hBEEF, 12));
		pending_cmds.push_back(make_cmd(0, 0, 0, 'hF, 'hFFFF, 0));
		pending_cmds.push_back(make_cmd(-32768, 32767, 0, 'h0, 'h0000, 0));
		pending_cmds.push_back(make_cmd(32760, -32760, 5, 'hF, 'hC0DE, 0));
		pending_cmds.push_back(make_cmd(-7, 7, 63, 'h6, 'h00FF, 0));
		pending_cmds.push_back(make_cmd(7, -7, 33, 'h9, 'hFF00, 7));
		pending_cmds.push_back(make_cmd(-32700, 32700, 1, 'hF, 'h8000, 0));

		// Random: stretches of back-to-back commands alternate with stretches
		// of random idle gaps, so start lands on every cycle of a busy command.
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 32 == 0)
				burst = ($urandom_range(0, 2) == 0);
			pending_cmds.push_back(make_cmd(pick_center(), pick_center(), pick_radius(),
				$urandom_range(0, 15), $urandom_range(0, 65535),
				burst ? 0 : $urandom_range(0, 12)));
		end

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// all commands presented and taken
		while (pending_cmds.size() != 0 || next_ok || start)
			@(posedge clk);
		// all predicted points seen, then a quiet window for stray strobes
		while (expected_points.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered %0d command transactions (%0d zero radius, %0d clipped radius)",
			cmds_taken, flat_cmds, clipped_cmds);
		$display("checked %0d octant points, %0d mismatches", points_seen, error_count);
		if (error_count == 0)
			$display("quarter_circle_outline_raster regression: pass");
		else
			$display("quarter_circle_outline_raster regression: fail");
		$finish;
	end

endmodule

@@ sim.f @@
hdl/qcor_pkg.sv
hdl/qcor_ctrl.sv
hdl/qcor_dp.sv
hdl/quarter_circle_outline_raster.sv
hdl/qcor_chk.sv
tb/quarter_circle_outline_raster_tb.sv
